// ----- design/irpfd_pkg.sv -----
`default_nettype none
package irpfd_pkg;

   localparam int MAX_RUNS_DEF   = 256;
   localparam int CODE_BITS_DEF  = 32;
   localparam int LEN_W          = 16;
   localparam int TIMER_W        = LEN_W + 1;
   localparam int CODE_W         = 32;
   localparam int COUNT_W        = 9;
   localparam int CSR_INDEX_W    = 3;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [LEN_W-1:0] TOLERANCE_RST   = 16'd200;
   localparam logic [LEN_W-1:0] TIMEOUT_RST     = 16'd20000;
   localparam logic [LEN_W-1:0] HEADER_1_RST    = 16'd4500;
   localparam logic [LEN_W-1:0] HEADER_2_RST    = 16'd4500;
   localparam logic [LEN_W-1:0] SKIP_RST        = 16'd550;
   localparam logic [LEN_W-1:0] ZERO_RST        = 16'd450;
   localparam logic [LEN_W-1:0] ONE_RST         = 16'd1450;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOLERANCE,
      CSR_TIMEOUT,
      CSR_HEADER_1,
      CSR_HEADER_2,
      CSR_SKIP,
      CSR_ZERO,
      CSR_ONE
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_BAD_HEADER,
      STATUS_NO_SKIP,
      STATUS_OVERFLOW
   } status_type;

   typedef struct packed {
      logic [LEN_W-1:0] tolerance;
      logic [LEN_W-1:0] timeout_ticks;
      logic [LEN_W-1:0] header_first_len;
      logic [LEN_W-1:0] header_second_len;
      logic [LEN_W-1:0] skip_len;
      logic [LEN_W-1:0] zero_len;
      logic [LEN_W-1:0] one_len;
   } cfg_type;

   typedef struct packed {
      logic             frame_end;
      logic [LEN_W-1:0] len;
   } event_type;

   function automatic logic [LEN_W-1:0] len_gap(input logic [LEN_W-1:0] a,
                                                input logic [LEN_W-1:0] b);
      len_gap = (a > b) ? a - b : b - a;
   endfunction

endpackage
`default_nettype wire

// ----- design/irpfd_front.sv -----
`default_nettype none
module irpfd_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_level,
   input  wire logic [irpfd_pkg::LEN_W-1:0] timeout_ticks,
   input  wire logic                     q_full,
   output logic                          push,
   output irpfd_pkg::event_type          push_event
);
   import irpfd_pkg::*;

   logic               busy_ff, busy_in;
   logic               level_ff, level_in;
   logic [TIMER_W-1:0] timer_ff, timer_in;
   logic               accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      busy_in          = busy_ff;
      level_in         = level_ff;
      timer_in         = timer_ff;
      push             = 1'b0;
      push_event.frame_end = 1'b0;
      push_event.len   = timer_ff[LEN_W-1:0];
      if (accept) begin
         if (!busy_ff) begin
            if (!req_level) begin
               busy_in  = 1'b1;
               level_in = 1'b0;
               timer_in = TIMER_W'(1);
            end
         end else if (req_level == level_ff) begin
            timer_in = timer_ff + TIMER_W'(1);
         end else begin
            push     = 1'b1;
            level_in = req_level;
            timer_in = TIMER_W'(1);
         end
         if (busy_in && (timer_in > {1'b0, timeout_ticks})) begin
            push                 = 1'b1;
            push_event.frame_end = 1'b1;
            busy_in              = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         level_ff <= 1'b0;
         timer_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         level_ff <= level_in;
         timer_ff <= timer_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/irpfd_queue.sv -----
`default_nettype none
module irpfd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire irpfd_pkg::event_type push_event,
   input  wire logic                 pop,
   output logic                      q_valid,
   output logic                      q_full,
   output irpfd_pkg::event_type      head_event
);
   import irpfd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   event_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               do_pop;

   assign q_valid    = count_ff != '0;
   assign q_full     = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head_event = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && q_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + (PTR_W+1)'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_event;
      end
   end

endmodule
`default_nettype wire

// ----- design/irpfd_back.sv -----
`default_nettype none
module irpfd_back #(
   parameter int MAX_RUNS  = irpfd_pkg::MAX_RUNS_DEF,
   parameter int CODE_BITS = irpfd_pkg::CODE_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire irpfd_pkg::cfg_type            cfg,
   input  wire logic                          q_valid,
   input  wire irpfd_pkg::event_type          head_event,
   output logic                               pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [irpfd_pkg::CODE_W-1:0]       rsp_code,
   output logic [1:0]                         rsp_status,
   output logic [irpfd_pkg::COUNT_W-1:0]      rsp_run_count
);
   import irpfd_pkg::*;

   localparam int RUNS_W = $clog2(MAX_RUNS + 1);

   logic [RUNS_W-1:0]    runs_ff, runs_in;
   logic [CODE_BITS-1:0] shift_ff, shift_in;
   logic                 hdr1_ok_ff, hdr1_ok_in;
   logic                 hdr_ok_ff, hdr_ok_in;
   logic                 skip_fault_ff, skip_fault_in;
   logic                 ovf_ff, ovf_in;

   logic                 out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]    out_code_ff, out_code_in;
   status_type           out_status_ff, out_status_in;
   logic [COUNT_W-1:0]   out_count_ff, out_count_in;

   logic                 out_free;
   logic [LEN_W-1:0]     len;
   logic                 near_hdr1, near_hdr2, near_skip, data_bit;
   logic [CODE_BITS-1:0] final_code;
   status_type           final_status;

   assign out_free = !out_valid_ff || rsp_ready;
   assign pop      = q_valid && (!head_event.frame_end || out_free);
   assign len      = head_event.len;

   assign near_hdr1 = len_gap(len, cfg.header_first_len) <= cfg.tolerance;
   assign near_hdr2 = len_gap(len, cfg.header_second_len) <= cfg.tolerance;
   assign near_skip = len_gap(len, cfg.skip_len) <= cfg.tolerance;
   assign data_bit  = !(len_gap(len, cfg.zero_len) < len_gap(len, cfg.one_len));

   always_comb begin
      final_code = runs_ff[0] ? {shift_ff[CODE_BITS-2:0], 1'b0} : shift_ff;
      if (ovf_ff) begin
         final_status = STATUS_OVERFLOW;
      end else if (runs_ff < RUNS_W'(2) || !hdr_ok_ff) begin
         final_status = STATUS_BAD_HEADER;
      end else if (skip_fault_ff) begin
         final_status = STATUS_NO_SKIP;
      end else begin
         final_status = STATUS_OK;
      end
   end

   always_comb begin
      runs_in       = runs_ff;
      shift_in      = shift_ff;
      hdr1_ok_in    = hdr1_ok_ff;
      hdr_ok_in     = hdr_ok_ff;
      skip_fault_in = skip_fault_ff;
      ovf_in        = ovf_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_code_in   = out_code_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (pop) begin
         if (head_event.frame_end) begin
            out_valid_in  = 1'b1;
            out_status_in = final_status;
            out_code_in   = (final_status == STATUS_OK) ? CODE_W'(final_code) : '0;
            out_count_in  = COUNT_W'(runs_ff);
            runs_in       = '0;
            shift_in      = '0;
            hdr1_ok_in    = 1'b0;
            hdr_ok_in     = 1'b0;
            skip_fault_in = 1'b0;
            ovf_in        = 1'b0;
         end else if (runs_ff == RUNS_W'(MAX_RUNS)) begin
            ovf_in = 1'b1;
         end else begin
            runs_in = runs_ff + RUNS_W'(1);
            if (runs_ff == '0) begin
               hdr1_ok_in = near_hdr1;
            end else if (runs_ff == RUNS_W'(1)) begin
               hdr_ok_in = hdr1_ok_ff && near_hdr2;
            end else if (!runs_ff[0]) begin
               if (!near_skip) begin
                  skip_fault_in = 1'b1;
               end
            end else begin
               shift_in = {shift_ff[CODE_BITS-2:0], data_bit};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         runs_ff       <= '0;
         shift_ff      <= '0;
         hdr1_ok_ff    <= 1'b0;
         hdr_ok_ff     <= 1'b0;
         skip_fault_ff <= 1'b0;
         ovf_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         runs_ff       <= runs_in;
         shift_ff      <= shift_in;
         hdr1_ok_ff    <= hdr1_ok_in;
         hdr_ok_ff     <= hdr_ok_in;
         skip_fault_ff <= skip_fault_in;
         ovf_ff        <= ovf_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_code_ff   <= out_code_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code      = out_code_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_run_count = out_count_ff;

endmodule
`default_nettype wire

// ----- design/ir_pulse_frame_decoder_unit.sv -----
`default_nettype none
// IR pulse frame decoder. Takes one sampled receiver pin level per item and
// accepts one item every clock; the run timer at the front only holds off
// req_ready when its four-entry event queue is full, which happens only while
// a finished frame result waits on rsp_ready. Each finished run goes through
// the queue to the back end, which checks header and skip runs, shifts in
// data bits and, when a run passes timeout_ticks, delivers one frame result
// (code, status, run_count) from an output register. The user must write the
// csr_ port registers only while no frame is in progress; it is not enforced.
module ir_pulse_frame_decoder_unit #(
   parameter int MAX_RUNS  = irpfd_pkg::MAX_RUNS_DEF,
   parameter int CODE_BITS = irpfd_pkg::CODE_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_level,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [irpfd_pkg::CODE_W-1:0]             rsp_code,
   output logic [1:0]                               rsp_status,
   output logic [irpfd_pkg::COUNT_W-1:0]            rsp_run_count,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [irpfd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [irpfd_pkg::LEN_W-1:0]         csr_wdata
);
   import irpfd_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_full, q_valid, push, pop;
   event_type push_event, head_event;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TOLERANCE: cfg_in.tolerance         = csr_wdata;
            CSR_TIMEOUT:   cfg_in.timeout_ticks     = csr_wdata;
            CSR_HEADER_1:  cfg_in.header_first_len  = csr_wdata;
            CSR_HEADER_2:  cfg_in.header_second_len = csr_wdata;
            CSR_SKIP:      cfg_in.skip_len          = csr_wdata;
            CSR_ZERO:      cfg_in.zero_len          = csr_wdata;
            CSR_ONE:       cfg_in.one_len           = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tolerance         <= TOLERANCE_RST;
         cfg_ff.timeout_ticks     <= TIMEOUT_RST;
         cfg_ff.header_first_len  <= HEADER_1_RST;
         cfg_ff.header_second_len <= HEADER_2_RST;
         cfg_ff.skip_len          <= SKIP_RST;
         cfg_ff.zero_len          <= ZERO_RST;
         cfg_ff.one_len           <= ONE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   irpfd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_level     (req_level),
      .timeout_ticks (cfg_ff.timeout_ticks),
      .q_full        (q_full),
      .push          (push),
      .push_event    (push_event)
   );

   irpfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_event (push_event),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_full     (q_full),
      .head_event (head_event)
   );

   irpfd_back #(
      .MAX_RUNS  (MAX_RUNS),
      .CODE_BITS (CODE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .head_event    (head_event),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_code      (rsp_code),
      .rsp_status    (rsp_status),
      .rsp_run_count (rsp_run_count)
   );

endmodule
`default_nettype wire

// ----- design/irpfd_checker.sv -----
`default_nettype none
module irpfd_checker #(
   parameter int MAX_RUNS = irpfd_pkg::MAX_RUNS_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [irpfd_pkg::CODE_W-1:0]   rsp_code,
   input wire logic [1:0]                     rsp_status,
   input wire logic [irpfd_pkg::COUNT_W-1:0]  rsp_run_count
);
   import irpfd_pkg::*;

   // failed frames carry no code
   a_err_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_code == '0)
      else $error("nonzero code on failed frame");

   // overflow saturates the run count
   a_ovf_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_OVERFLOW |-> rsp_run_count == COUNT_W'(MAX_RUNS))
      else $error("overflow with wrong run count");

   // nothing comes out right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

endmodule

bind ir_pulse_frame_decoder_unit irpfd_checker #(.MAX_RUNS(MAX_RUNS)) u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_code      (rsp_code),
   .rsp_status    (rsp_status),
   .rsp_run_count (rsp_run_count)
);
`default_nettype wire
